// ----- src/fdre_pkg.sv -----
// Shared types and constants of the frame delta run-length encoder.
package fdre_pkg;

   localparam int unsigned PIX_W  = 8;
   localparam int unsigned RUN_W  = 15;
   localparam int unsigned ADDR_W = 7;
   localparam int unsigned TOT_W  = 21;
   localparam int unsigned WORD_W = 64;
   localparam int unsigned CNT_W  = 4;
   localparam int unsigned DEPTH  = 128;
   localparam int unsigned LANES  = WORD_W / PIX_W;

   localparam logic [RUN_W-1:0]  RUN_CAP       = 15'd16385;
   localparam logic [RUN_W-1:0]  SHORT_RUN_MAX = 15'd66;
   localparam logic [RUN_W-1:0]  MIN_RUN       = 15'd3;
   localparam logic [ADDR_W-1:0] LIT_CAP       = 7'd127;
   localparam logic [TOT_W-1:0]  TOTAL_SAT     = 21'h1FFFFF;

   typedef enum logic [1:0] {
      SEG_NONE = 2'd0,
      SEG_RUN  = 2'd1,
      SEG_LIT  = 2'd2
   } seg_kind_type;

   // one code segment: a run (val = run length) or a literal rung (val = pixel count)
   typedef struct packed {
      seg_kind_type     kind;
      logic [RUN_W-1:0] val;
   } seg_type;

   typedef struct packed {
      seg_type           head;
      seg_type           tail;
      logic              wr_en;
      logic              defer;
      logic [ADDR_W-1:0] wr_addr;
   } plan_type;

   typedef struct packed {
      logic              push;
      logic [PIX_W-1:0]  data;
      logic              step_end;
      logic              frame_end;
      logic [ADDR_W-1:0] lit_add;
   } byte_push_type;

endpackage

// ----- src/fdre_store.sv -----
// Literal pixel store: 128 x 8 synchronous RAM, one write and one registered read port.
module fdre_store (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [fdre_pkg::ADDR_W-1:0]   wr_addr,
   input  logic [fdre_pkg::PIX_W-1:0]    wr_data,
   input  logic [fdre_pkg::ADDR_W-1:0]   rd_addr,
   output logic [fdre_pkg::PIX_W-1:0]    rd_data
);
   import fdre_pkg::*;

   logic [PIX_W-1:0] store_ff [DEPTH];
   logic [PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/fdre_plan.sv -----
// Coder state (equal run, literal count, forced count) and per-pixel segment planning.
module fdre_plan (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [fdre_pkg::PIX_W-1:0]  old_pixel,
   input  logic [fdre_pkg::PIX_W-1:0]  new_pixel,
   input  logic                        frame_last,
   output fdre_pkg::plan_type          plan
);
   import fdre_pkg::*;

   logic [RUN_W-1:0]  er_ff, er_in;
   logic [ADDR_W-1:0] lc_ff, lc_in;
   logic [1:0]        fl_ff, fl_in;

   logic              same;
   logic [RUN_W-1:0]  er1;
   logic [ADDR_W-1:0] lc1;
   logic [1:0]        c_lo;
   logic [ADDR_W-1:0] new_lc;

   always_comb begin
      same   = (old_pixel == new_pixel);
      er1    = er_ff + 15'd1;
      lc1    = lc_ff + 7'd1;
      c_lo   = (er_ff >= MIN_RUN) ? 2'd0 : er_ff[1:0];
      new_lc = {5'd0, c_lo} + 7'd1;

      plan   = '0;
      er_in  = er_ff;
      lc_in  = lc_ff;
      fl_in  = fl_ff;

      if (lc_ff != '0) begin
         if (fl_ff != 2'd0 || !same) begin
            // pixel joins the open rung
            plan.wr_en   = 1'b1;
            plan.wr_addr = lc_ff;
            fl_in        = (fl_ff != 2'd0) ? fl_ff - 2'd1 : 2'd0;
            lc_in        = lc1;
            if (lc1 >= LIT_CAP || frame_last) begin
               plan.tail.kind = SEG_LIT;
               plan.tail.val  = {8'd0, lc1};
               lc_in          = '0;
               fl_in          = 2'd0;
            end
            if (frame_last) begin
               er_in = '0;
            end
         end else begin
            // equal pixel closes the rung; store slot 0 is reused after the rung is read
            plan.head.kind = SEG_LIT;
            plan.head.val  = {8'd0, lc_ff};
            plan.wr_en     = 1'b1;
            plan.defer     = 1'b1;
            plan.wr_addr   = '0;
            lc_in          = '0;
            fl_in          = 2'd0;
            er_in          = 15'd1;
            if (frame_last) begin
               plan.tail.kind = SEG_LIT;
               plan.tail.val  = 15'd1;
               er_in          = '0;
            end
         end
      end else if (same) begin
         plan.wr_en   = (er_ff < 15'd2);
         plan.wr_addr = {5'd0, er_ff[1:0]};
         er_in        = er1;
         if (er1 >= RUN_CAP) begin
            plan.tail.kind = SEG_RUN;
            plan.tail.val  = er1;
            er_in          = '0;
         end else if (frame_last) begin
            plan.tail.kind = (er1 >= MIN_RUN) ? SEG_RUN : SEG_LIT;
            plan.tail.val  = er1;
            er_in          = '0;
         end
      end else begin
         if (er_ff >= MIN_RUN) begin
            plan.head.kind = SEG_RUN;
            plan.head.val  = er_ff;
         end
         plan.wr_en   = 1'b1;
         plan.wr_addr = {5'd0, c_lo};
         er_in        = '0;
         lc_in        = new_lc;
         fl_in        = (c_lo == 2'd1) ? 2'd1 : 2'd0;
         if (frame_last) begin
            plan.tail.kind = SEG_LIT;
            plan.tail.val  = {8'd0, new_lc};
            lc_in          = '0;
            fl_in          = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         er_ff <= '0;
         lc_ff <= '0;
         fl_ff <= '0;
      end else if (accept) begin
         er_ff <= er_in;
         lc_ff <= lc_in;
         fl_ff <= fl_in;
      end
   end

   a_rung_excludes_run: assert property (@(posedge clock) disable iff (reset)
      (lc_ff != '0) |-> (er_ff == '0))
      else $error("equal run pending while a literal rung is open");

   a_forced_only_short: assert property (@(posedge clock) disable iff (reset)
      (fl_ff != 2'd0) |-> (lc_ff == 7'd2))
      else $error("forced count set outside a two-pixel forced rung");

endmodule

// ----- src/fdre_packer.sv -----
// Byte packer: gathers code bytes into 64-bit words, keeps frame totals, holds the response.
module fdre_packer (
   input  logic                          clock,
   input  logic                          reset,
   input  fdre_pkg::byte_push_type       pk,
   output logic                          go,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [fdre_pkg::WORD_W-1:0]   rsp_code_bytes,
   output logic [fdre_pkg::CNT_W-1:0]    rsp_byte_count,
   output logic                          rsp_frame_done,
   output logic [fdre_pkg::TOT_W-1:0]    rsp_encoded_length,
   output logic [fdre_pkg::TOT_W-1:0]    rsp_literal_total
);
   import fdre_pkg::*;

   logic [WORD_W-1:0] word_ff, word_in;
   logic [2:0]        fill_ff, fill_in;
   logic [TOT_W-1:0]  len_tot_ff, len_tot_in;
   logic [TOT_W-1:0]  lit_tot_ff, lit_tot_in;
   logic              valid_ff, valid_in;
   logic [WORD_W-1:0] code_ff, code_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              done_ff, done_in;
   logic [TOT_W-1:0]  enc_ff, enc_in;
   logic [TOT_W-1:0]  lsum_ff, lsum_in;

   logic [WORD_W-1:0] merged;
   logic [CNT_W-1:0]  fill1;
   logic              complete;
   logic              out_free;
   logic [TOT_W-1:0]  len_next;
   logic [TOT_W:0]    lit_wide;
   logic [TOT_W-1:0]  lit_next;

   always_comb begin
      merged   = word_ff | ({{(WORD_W-PIX_W){1'b0}}, pk.data} << {fill_ff, 3'b000});
      fill1    = {1'b0, fill_ff} + 4'd1;
      complete = pk.step_end || (fill1 == 4'(LANES));
      out_free = !valid_ff || !rsp_stall;
      go       = !complete || out_free;

      len_next = (len_tot_ff == TOTAL_SAT) ? len_tot_ff : len_tot_ff + 21'd1;
      lit_wide = {1'b0, lit_tot_ff} + {15'd0, pk.lit_add};
      lit_next = lit_wide[TOT_W] ? TOTAL_SAT : lit_wide[TOT_W-1:0];

      word_in    = word_ff;
      fill_in    = fill_ff;
      len_tot_in = len_tot_ff;
      lit_tot_in = lit_tot_ff;
      valid_in   = valid_ff && rsp_stall;
      code_in    = code_ff;
      count_in   = count_ff;
      done_in    = done_ff;
      enc_in     = enc_ff;
      lsum_in    = lsum_ff;

      if (pk.push && go) begin
         len_tot_in = len_next;
         lit_tot_in = lit_next;
         if (complete) begin
            word_in  = '0;
            fill_in  = '0;
            valid_in = 1'b1;
            code_in  = merged;
            count_in = fill1;
            done_in  = pk.frame_end;
            enc_in   = pk.frame_end ? len_next : '0;
            lsum_in  = pk.frame_end ? lit_next : '0;
            if (pk.frame_end) begin
               len_tot_in = '0;
               lit_tot_in = '0;
            end
         end else begin
            word_in = merged;
            fill_in = fill1[2:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff    <= '0;
         fill_ff    <= '0;
         len_tot_ff <= '0;
         lit_tot_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         word_ff    <= word_in;
         fill_ff    <= fill_in;
         len_tot_ff <= len_tot_in;
         lit_tot_ff <= lit_tot_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff  <= code_in;
      count_ff <= count_in;
      done_ff  <= done_in;
      enc_ff   <= enc_in;
      lsum_ff  <= lsum_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_code_bytes     = code_ff;
   assign rsp_byte_count     = count_ff;
   assign rsp_frame_done     = done_ff;
   assign rsp_encoded_length = enc_ff;
   assign rsp_literal_total  = lsum_ff;

   a_totals_cleared: assert property (@(posedge clock) disable iff (reset)
      (pk.push && go && pk.frame_end) |=> (len_tot_ff == '0 && lit_tot_ff == '0))
      else $error("frame totals not cleared after frame end");

   a_total_covers_word: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && done_ff) |-> (enc_ff >= {17'd0, count_ff}))
      else $error("frame length below bytes of final word");

endmodule

// ----- src/frame_delta_rle_encoder_unit.sv -----
// Top level of the frame delta run-length encoder: request sequencer and unit wiring.
//
// Usage:
//  - Request channel (req_*): one (old pixel, new pixel, frame_last) per request,
//    taken at a clock edge with req_valid high and req_stall low.
//  - Response channel (rsp_*): up to eight code bytes per response, first byte in
//    bits 7..0, unused lanes zero. The last response of a frame has rsp_frame_done
//    set and carries the saturating frame totals; the totals read zero otherwise.
//  - A request that completes no code leaves req_stall low. A request that emits N code
//    bytes holds req_stall until its last byte is packed; the byte sequencer moves
//    one byte a cycle while the packer accepts, bounded by the single read port of
//    the literal store. N is at most 129 (a closing 126-pixel rung plus a one-pixel
//    rung at frame end).
//  - Response words become valid as each fills eight bytes or the bytes run out.
//  - A finished word waits in the response register; while rsp_stall is high the
//    sequencer keeps filling the next word and halts at the byte that would fill it
//    or that is the request's last byte.
//  - Reset (synchronous, active high) clears coder state and totals. The literal
//    store is not cleared; it is only read at entries written for the pending rung.
module frame_delta_rle_encoder_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [fdre_pkg::PIX_W-1:0]    req_old_pixel,
   input  logic [fdre_pkg::PIX_W-1:0]    req_new_pixel,
   input  logic                          req_frame_last,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [fdre_pkg::WORD_W-1:0]   rsp_code_bytes,
   output logic [fdre_pkg::CNT_W-1:0]    rsp_byte_count,
   output logic                          rsp_frame_done,
   output logic [fdre_pkg::TOT_W-1:0]    rsp_encoded_length,
   output logic [fdre_pkg::TOT_W-1:0]    rsp_literal_total
);
   import fdre_pkg::*;

   // IDLE takes requests; HEAD emits the segment closed before the store write
   // (a run, or the old rung); TAIL emits the segment closed after it.
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_HEAD = 3'b010,
      ST_TAIL = 3'b100
   } seq_state_type;

   seq_state_type     state_ff, state_in;
   logic [ADDR_W-1:0] j_ff, j_in;
   seg_type           head_ff, head_in;
   seg_type           tail_ff, tail_in;
   logic              last_ff, last_in;
   logic              wr_pend_ff, wr_pend_in;
   logic [ADDR_W-1:0] pend_addr_ff, pend_addr_in;
   logic [PIX_W-1:0]  pend_data_ff, pend_data_in;

   plan_type          plan;
   byte_push_type     pk;
   logic              go;
   logic              accept;
   logic              need_bytes;
   logic              defer_fire;

   seg_type           seg;
   logic              long_run;
   logic [RUN_W-1:0]  run_v;
   logic [ADDR_W-1:0] last_idx;
   logic              seg_end;
   logic              tail_empty;

   logic              st_wr_en;
   logic [ADDR_W-1:0] st_wr_addr;
   logic [PIX_W-1:0]  st_wr_data;
   logic [ADDR_W-1:0] st_rd_addr;
   logic [PIX_W-1:0]  st_rd_data;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   fdre_plan u_plan (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .old_pixel  (req_old_pixel),
      .new_pixel  (req_new_pixel),
      .frame_last (req_frame_last),
      .plan       (plan)
   );

   // current segment and the byte it emits this cycle
   always_comb begin
      seg        = (state_ff == ST_HEAD) ? head_ff : tail_ff;
      tail_empty = (tail_ff.kind == SEG_NONE);
      long_run   = (seg.val > SHORT_RUN_MAX);
      run_v      = seg.val - MIN_RUN;
      last_idx   = (seg.kind == SEG_RUN) ? {6'd0, long_run} : seg.val[ADDR_W-1:0];
      seg_end    = (j_ff == last_idx);

      pk.push      = (state_ff != ST_IDLE);
      pk.step_end  = seg_end && ((state_ff == ST_TAIL) || tail_empty);
      pk.frame_end = seg_end && ((state_ff == ST_TAIL) || tail_empty) && last_ff;
      pk.lit_add   = '0;
      pk.data      = '0;

      case (seg.kind)
         SEG_RUN: begin
            if (j_ff != '0) begin
               pk.data = run_v[13:6];
            end else if (long_run) begin
               pk.data = {2'b11, run_v[5:0]};
            end else begin
               pk.data = {2'b10, run_v[5:0]};
            end
         end
         SEG_LIT: begin
            if (j_ff == '0) begin
               // rung header: pixel count minus one
               pk.data    = {1'b0, seg.val[ADDR_W-1:0] - 7'd1};
               pk.lit_add = seg.val[ADDR_W-1:0];
            end else begin
               pk.data = st_rd_data;
            end
         end
         default: begin
            pk.data = '0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      j_in         = j_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      last_in      = last_ff;
      wr_pend_in   = wr_pend_ff;
      pend_addr_in = pend_addr_ff;
      pend_data_in = pend_data_ff;
      defer_fire   = 1'b0;
      need_bytes   = (plan.head.kind != SEG_NONE) || (plan.tail.kind != SEG_NONE);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               head_in      = plan.head;
               tail_in      = plan.tail;
               last_in      = req_frame_last;
               wr_pend_in   = plan.wr_en && plan.defer;
               pend_addr_in = plan.wr_addr;
               pend_data_in = req_new_pixel;
               j_in         = '0;
               if (need_bytes) begin
                  state_in = (plan.head.kind != SEG_NONE) ? ST_HEAD : ST_TAIL;
               end
            end
         end
         ST_HEAD: begin
            if (go) begin
               if (seg_end) begin
                  j_in       = '0;
                  // old rung fully read: slot 0 may now take the new pixel
                  defer_fire = wr_pend_ff;
                  wr_pend_in = 1'b0;
                  state_in   = tail_empty ? ST_IDLE : ST_TAIL;
               end else begin
                  j_in = j_ff + 7'd1;
               end
            end
         end
         ST_TAIL: begin
            if (go) begin
               if (seg_end) begin
                  j_in     = '0;
                  state_in = ST_IDLE;
               end else begin
                  j_in = j_ff + 7'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
            j_in     = '0;
         end
      endcase
   end

   // store access: byte j of a rung is entry j-1, read in the cycle before its use
   always_comb begin
      st_wr_en   = (accept && plan.wr_en && !plan.defer) || defer_fire;
      st_wr_addr = defer_fire ? pend_addr_ff : plan.wr_addr;
      st_wr_data = defer_fire ? pend_data_ff : req_new_pixel;
      st_rd_addr = j_in - 7'd1;
   end

   fdre_store u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   fdre_packer u_packer (
      .clock              (clock),
      .reset              (reset),
      .pk                 (pk),
      .go                 (go),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_code_bytes     (rsp_code_bytes),
      .rsp_byte_count     (rsp_byte_count),
      .rsp_frame_done     (rsp_frame_done),
      .rsp_encoded_length (rsp_encoded_length),
      .rsp_literal_total  (rsp_literal_total)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         j_ff       <= '0;
         wr_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         j_ff       <= j_in;
         wr_pend_ff <= wr_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff      <= head_in;
      tail_ff      <= tail_in;
      last_ff      <= last_in;
      pend_addr_ff <= pend_addr_in;
      pend_data_ff <= pend_data_in;
   end

   a_pend_in_head: assert property (@(posedge clock) disable iff (reset)
      wr_pend_ff |-> (state_ff == ST_HEAD))
      else $error("deferred store write outside head segment");

   a_index_in_segment: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (j_ff <= last_idx))
      else $error("byte index ran past segment end");

endmodule
